// ===== src/cms_pkg.sv =====
`default_nettype none
package cms_pkg;

  // item kinds
  localparam logic [1:0] KIND_GET = 2'd0;
  localparam logic [1:0] KIND_INC = 2'd1;
  localparam logic [1:0] KIND_DEC = 2'd2;
  localparam logic [1:0] KIND_SET = 2'd3;

  // size registers
  localparam int NUM_SIZE_REGS = 4;
  localparam int SIZE_REG_W    = 13;
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET [NUM_SIZE_REGS] =
    '{13'd4093, 13'd4091, 13'd4079, 13'd4073};

  localparam int HASH_W   = 64;
  localparam int AMOUNT_W = 32;
  localparam int EST_W    = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== src/count_min_sketch.sv =====
`default_nettype none
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: kind; tdata: key_hash, amount
// m_*       out  m_tvalid/m_tready  tdata: estimate (get only)
// apb       in   psel/penable       table_size_0..3 at 0x0, 0x4, 0x8, 0xc
//
// an item passes through the accept state, then per table the bit-serial
// hash remainder over every hash bit, a ram read and an update or compare
// step; a get adds a step to hand its result to the output register, and
// that step waits while the register still holds an unaccepted result.
// after reset a clearing pass writes NUM_TABLES * TABLE_DEPTH zeros, one
// counter a cycle, while s_tready stays low; apb writes are taken meanwhile.
// the output register holds a result while m_tready is low; a new item is
// taken meanwhile, and a following get waits for the register to drain.
module count_min_sketch
  import cms_pkg::*;
#(
  parameter int NUM_TABLES  = 4,
  parameter int TABLE_DEPTH = 4096,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // key_hash [63:0], amount [95:64]
  input  wire logic [1:0]  s_tuser,   // kind [1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // estimate [31:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int ENTRIES = NUM_TABLES * TABLE_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int TW      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int SW      = $clog2(TABLE_DEPTH + 1);
  localparam int BW      = $clog2(HASH_W);

  state_t state, state_next;

  logic [SIZE_REG_W-1:0]  size_reg [NUM_SIZE_REGS];
  logic [AW-1:0]          clr_addr;
  logic [TW-1:0]          tbl;
  logic [BW-1:0]          bit_cnt;
  logic [SW-1:0]          rem;
  logic [1:0]             kind_q;
  logic [HASH_W-1:0]      hash_q;
  logic [COUNT_WIDTH-1:0] amt_q;
  logic [COUNT_WIDTH-1:0] minv;
  logic [EST_W-1:0]       est;

  logic [SW-1:0]          eff;
  logic [SW:0]            rem_sh;
  logic [SW-1:0]          rem_step;
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic                   apb_wr;

  // apb register file
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;
  assign prdata = 32'(size_reg[paddr[3:2]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SIZE_REGS; i++) begin
        size_reg[i] <= SIZE_RESET[i];
      end
    end else if (apb_wr) begin
      size_reg[paddr[3:2]] <= pwdata[SIZE_REG_W-1:0];
    end
  end

  // effective modulus of the current table
  always_comb begin
    logic [2:0]  t3;
    logic [20:0] s;
    t3 = 3'(tbl);
    s  = 21'(TABLE_DEPTH);
    if (t3 < 3'(NUM_SIZE_REGS)) begin
      s = 21'(size_reg[t3[1:0]]);
      if (s == 21'd0) begin
        s = 21'd1;
      end
      if (s > 21'(TABLE_DEPTH)) begin
        s = 21'(TABLE_DEPTH);
      end
    end
    eff = SW'(s);
  end

  // one restoring remainder step, msb of the hash first
  always_comb begin
    rem_sh = {rem, hash_q[bit_cnt]};
    if (rem_sh >= {1'b0, eff}) begin
      rem_step = SW'(rem_sh - {1'b0, eff});
    end else begin
      rem_step = SW'(rem_sh);
    end
  end

  // counter memory
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_addr = clr_addr;
    end else begin
      ram_addr = AW'(AW'(tbl) * AW'(TABLE_DEPTH)) + AW'(rem);
    end
  end

  always_comb begin
    case (kind_q)
      KIND_INC: ram_wdata = ram_rdata + amt_q;
      KIND_DEC: ram_wdata = ram_rdata - amt_q;
      default:  ram_wdata = amt_q;
    endcase
    if (state == ST_CLEAR) begin
      ram_wdata = '0;
    end
  end

  assign ram_we = (state == ST_CLEAR) || (state == ST_UPDATE && kind_q != KIND_GET);

  cms_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (bit_cnt == '0) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (tbl == TW'(NUM_TABLES - 1)) begin
          state_next = (kind_q == KIND_GET) ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_MOD;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      // output register: load a get result or drain on accept
      if (state == ST_EMIT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          kind_q  <= s_tuser;
          hash_q  <= s_tdata[63:0];
          amt_q   <= COUNT_WIDTH'(s_tdata[95:64]);
          tbl     <= '0;
          bit_cnt <= BW'(HASH_W - 1);
          rem     <= '0;
        end
        ST_MOD: begin
          rem     <= rem_step;
          bit_cnt <= bit_cnt - BW'(1);
        end
        ST_UPDATE: begin
          if (tbl == '0 || ram_rdata < minv) begin
            minv <= ram_rdata;
          end
          tbl     <= tbl + TW'(1);
          bit_cnt <= BW'(HASH_W - 1);
          rem     <= '0;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            est <= EST_W'(minv);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tdata = est;

  // checks
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("item taken during clearing pass");

  a_bin_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> rem < eff)
    else $error("bin not below table size");

  a_get_no_write: assert property (@(posedge clk) disable iff (rst)
    state != ST_CLEAR && kind_q == KIND_GET |-> !ram_we)
    else $error("get wrote the counter memory");

  a_read_then_update: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_UPDATE && $stable(ram_addr))
    else $error("update address moved after read");

endmodule
`default_nettype wire

// ===== src/cms_ram.sv =====
`default_nettype none
module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire
